FILE: hw/rtl/iext_pkg.sv
// Shared types, character codes and helpers for the ISA extension finder.
// No dependencies.
package iext_pkg;

    typedef logic [7:0] char_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_QUERY_NAME   = 1'b0,
        CFG_QUERY_LENGTH = 1'b1
    } cfg_index_t;

    localparam char_t CH_NUL  = 8'h00;
    localparam char_t CH_ZERO = 8'h30;
    localparam char_t CH_NINE = 8'h39;
    localparam char_t CH_UC_A = 8'h41;
    localparam char_t CH_UC_Z = 8'h5a;
    localparam char_t CH_US   = 8'h5f;
    localparam char_t CH_LC_A = 8'h61;
    localparam char_t CH_P    = 8'h70;
    localparam char_t CH_S    = 8'h73;
    localparam char_t CH_X    = 8'h78;
    localparam char_t CH_Z    = 8'h7a;
    localparam char_t CASE_BIT = 8'h20;

    function automatic char_t to_lower(input char_t c);
        return (c >= CH_UC_A && c <= CH_UC_Z) ? (c | CASE_BIT) : c;
    endfunction

    function automatic logic is_alpha(input char_t c);
        char_t l;
        l = to_lower(c);
        return (l >= CH_LC_A && l <= CH_Z);
    endfunction

    function automatic logic is_digit(input char_t c);
        return (c >= CH_ZERO && c <= CH_NINE);
    endfunction

endpackage

FILE: hw/rtl/iext_channels.sv
// Valid/ready channel interfaces: ISA string characters in, search result out.
// Depends on iext_pkg.
interface iext_char_if
    import iext_pkg::*;
();
    logic  valid;
    logic  ready;
    char_t ch;
    logic  final_char;

    modport source (output valid, output ch, output final_char, input ready);
    modport sink   (input valid, input ch, input final_char, output ready);
endinterface

interface iext_result_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [15:0] major_version;
    logic [15:0] minor_version;

    modport source (output valid, output found, output major_version, output minor_version,
                    input ready);
    modport sink   (input valid, input found, input major_version, input minor_version,
                    output ready);
endinterface

FILE: hw/rtl/isa_extension_finder.sv
// Top level of the ISA extension finder: character parser and result register.
// Depends on iext_pkg and the channel interfaces in iext_channels.sv.
//
// Usage:
//   chars  : one ISA string character per word, final_char set on the last one.
//   result : one word per string, sent after the word with final_char set;
//            found plus the major/minor version of the first matching extension.
//   wr_*   : query name (index CFG_QUERY_NAME) and length (CFG_QUERY_LENGTH),
//            written while no string is in flight.
// Throughput is one character per cycle while chars.ready is high; the parser
// state updates in the cycle the character is accepted. The result word is held
// in the result register and is valid in the cycle after the final character.
// The result register parts the two sides: chars.ready drops only while a
// result word is held and the receiver has not taken it; then characters
// wait with it.
// Reset clears the parser to the start of a string, the query name to zero
// and the query length to one. After each result the parser returns to the
// start of a string by itself.
module isa_extension_finder
    import iext_pkg::*;
#(
    parameter int NAME_CHARS   = 8,
    parameter int VERSION_BITS = 16,
    parameter int PREFIX_LEN   = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    iext_char_if.sink         chars,
    iext_result_if.source     result,
    input  logic              wr_en,
    input  cfg_index_t        wr_index,
    input  logic [63:0]       wr_data
);

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_START,
        PH_RUN,
        PH_NAMED,
        PH_MAJOR,
        PH_MINOR,
        PH_TAIL,
        PH_DONE
    } phase_t;

    typedef logic [VERSION_BITS-1:0] ver_t;

    localparam phase_t PH_RESET = (PREFIX_LEN == 0) ? PH_START : PH_PREFIX;
    localparam logic [3:0] POS_MAX = 4'hf;

    // Decimal accumulate, saturating at all ones
    function automatic ver_t accum(input ver_t acc, input logic [3:0] d);
        logic [VERSION_BITS+3:0] wide;
        wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (VERSION_BITS+4)'(d);
        return (wide[VERSION_BITS+3:VERSION_BITS] != 4'b0) ? '1 : wide[VERSION_BITS-1:0];
    endfunction

    logic [63:0] query_name_reg;
    logic [3:0]  query_length_reg;

    phase_t      phase_reg, phase_next;
    logic [2:0]  prefix_count_reg, prefix_count_next;
    logic [3:0]  pos_reg, pos_next;
    logic        matching_reg, matching_next;
    ver_t        major_reg, major_next;
    ver_t        minor_reg, minor_next;
    logic        latched_reg, latched_next;
    ver_t        latched_major_reg, latched_major_next;
    ver_t        latched_minor_reg, latched_minor_next;

    logic        out_valid_reg;
    logic        out_found_reg, out_found_next;
    logic [15:0] out_major_reg, out_major_next;
    logic [15:0] out_minor_reg, out_minor_next;

    logic        accept;
    logic        hit_first, hit_pos;
    char_t       query_char;

    assign chars.ready = !out_valid_reg || result.ready;
    assign accept      = chars.valid && chars.ready;

    assign query_char = query_name_reg[{pos_reg[2:0], 3'b000} +: 8];
    assign hit_first  = (query_length_reg != 4'd0)
                        && (to_lower(query_name_reg[7:0]) == to_lower(chars.ch));
    assign hit_pos    = (pos_reg < query_length_reg) && (pos_reg < 4'(NAME_CHARS))
                        && (to_lower(query_char) == to_lower(chars.ch));

    always_comb
    begin
        logic do_close;
        logic do_tail;
        logic do_begin;
        logic do_cmp;
        logic end_hit;
        logic [31:0] maj_wide;
        logic [31:0] min_wide;

        do_close = 1'b0;
        do_tail  = 1'b0;
        do_begin = 1'b0;
        do_cmp   = 1'b0;
        end_hit  = 1'b0;
        maj_wide = '0;
        min_wide = '0;

        phase_next         = phase_reg;
        prefix_count_next  = prefix_count_reg;
        pos_next           = pos_reg;
        matching_next      = matching_reg;
        major_next         = major_reg;
        minor_next         = minor_reg;
        latched_next       = latched_reg;
        latched_major_next = latched_major_reg;
        latched_minor_next = latched_minor_reg;
        out_found_next     = out_found_reg;
        out_major_next     = out_major_reg;
        out_minor_next     = out_minor_reg;

        if (accept)
        begin
            priority if (phase_reg == PH_PREFIX)
            begin
                prefix_count_next = prefix_count_reg + 3'd1;
                if ({1'b0, prefix_count_reg} + 4'd1 >= 4'(PREFIX_LEN))
                    phase_next = PH_START;
            end
            else if (phase_reg == PH_DONE)
            begin
                phase_next = PH_DONE;
            end
            else if (chars.ch == CH_NUL)
            begin
                // NUL ends the string; rest up to the final word is ignored
                do_close   = (phase_reg == PH_RUN) || (phase_reg == PH_NAMED)
                             || (phase_reg == PH_MAJOR) || (phase_reg == PH_MINOR);
                phase_next = PH_DONE;
            end
            else
            begin
                unique case (phase_reg)
                    PH_START:
                        do_begin = 1'b1;
                    PH_RUN, PH_NAMED:
                    begin
                        if (phase_reg == PH_RUN && is_alpha(chars.ch))
                            do_cmp = 1'b1;
                        else if (is_digit(chars.ch))
                        begin
                            major_next = accum('0, chars.ch[3:0]);
                            phase_next = PH_MAJOR;
                        end
                        else
                        begin
                            do_close = 1'b1;
                            do_tail  = 1'b1;
                        end
                    end
                    PH_MAJOR:
                    begin
                        if (is_digit(chars.ch))
                            major_next = accum(major_reg, chars.ch[3:0]);
                        else if (chars.ch == CH_P)
                            phase_next = PH_MINOR;
                        else
                        begin
                            do_close = 1'b1;
                            do_tail  = 1'b1;
                        end
                    end
                    PH_MINOR:
                    begin
                        if (is_digit(chars.ch))
                            minor_next = accum(minor_reg, chars.ch[3:0]);
                        else
                        begin
                            do_close = 1'b1;
                            do_tail  = 1'b1;
                        end
                    end
                    PH_TAIL:
                        do_tail = 1'b1;
                    default:
                        phase_next = phase_reg;
                endcase
            end

            // close uses the values of the extension that just ended
            if (do_close && !latched_reg && matching_reg && pos_reg == query_length_reg)
            begin
                latched_next       = 1'b1;
                latched_major_next = major_reg;
                latched_minor_next = minor_reg;
            end

            if (do_tail)
            begin
                if (chars.ch == CH_US)
                    phase_next = PH_TAIL;
                else
                    do_begin = 1'b1;
            end

            if (do_begin)
            begin
                pos_next      = 4'd1;
                matching_next = hit_first;
                major_next    = '0;
                minor_next    = '0;
                phase_next    = (to_lower(chars.ch) == CH_S || to_lower(chars.ch) == CH_X
                                 || to_lower(chars.ch) == CH_Z) ? PH_RUN : PH_NAMED;
            end

            if (do_cmp)
            begin
                matching_next = matching_reg && hit_pos;
                pos_next      = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 4'd1;
            end

            if (chars.final_char)
            begin
                end_hit = ((phase_next == PH_RUN) || (phase_next == PH_NAMED)
                           || (phase_next == PH_MAJOR) || (phase_next == PH_MINOR))
                          && !latched_next && matching_next && pos_next == query_length_reg;
                if (latched_next)
                begin
                    maj_wide = 32'(latched_major_next);
                    min_wide = 32'(latched_minor_next);
                end
                else if (end_hit)
                begin
                    maj_wide = 32'(major_next);
                    min_wide = 32'(minor_next);
                end
                out_found_next = latched_next || end_hit;
                out_major_next = maj_wide[15:0];
                out_minor_next = min_wide[15:0];

                phase_next         = PH_RESET;
                prefix_count_next  = '0;
                pos_next           = '0;
                matching_next      = 1'b0;
                major_next         = '0;
                minor_next         = '0;
                latched_next       = 1'b0;
                latched_major_next = '0;
                latched_minor_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_name_reg    <= '0;
            query_length_reg  <= 4'd1;
            phase_reg         <= PH_RESET;
            prefix_count_reg  <= '0;
            pos_reg           <= '0;
            matching_reg      <= 1'b0;
            major_reg         <= '0;
            minor_reg         <= '0;
            latched_reg       <= 1'b0;
            latched_major_reg <= '0;
            latched_minor_reg <= '0;
            out_valid_reg     <= 1'b0;
            out_found_reg     <= 1'b0;
            out_major_reg     <= '0;
            out_minor_reg     <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (wr_index)
                    CFG_QUERY_NAME:   query_name_reg   <= wr_data;
                    CFG_QUERY_LENGTH: query_length_reg <= wr_data[3:0];
                    default:          query_name_reg   <= query_name_reg;
                endcase
            end
            phase_reg         <= phase_next;
            prefix_count_reg  <= prefix_count_next;
            pos_reg           <= pos_next;
            matching_reg      <= matching_next;
            major_reg         <= major_next;
            minor_reg         <= minor_next;
            latched_reg       <= latched_next;
            latched_major_reg <= latched_major_next;
            latched_minor_reg <= latched_minor_next;
            if (accept && chars.final_char)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
            // payload changes only with a final character
            out_found_reg     <= out_found_next;
            out_major_reg     <= out_major_next;
            out_minor_reg     <= out_minor_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.found         = out_found_reg;
    assign result.major_version = out_major_reg;
    assign result.minor_version = out_minor_reg;

`ifndef SYNTHESIS
    a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        chars.valid && chars.ready && chars.final_char |=> result.valid)
        else $error("final character did not produce a result");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        chars.valid && chars.ready && !chars.final_char && !result.valid |=> !result.valid)
        else $error("result without a final character");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.found |-> result.major_version == 16'd0
                                          && result.minor_version == 16'd0)
        else $error("versions nonzero without a match");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |-> !chars.ready)
        else $error("input taken while result is stalled");
`endif

endmodule
